>>> rtl/tpm_pkg.sv
package tpm_pkg;

  // filter geometry
  localparam int TAPS       = 12;
  localparam int PHASES     = 4;

  // field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 15;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int PEAK_W     = 25;
  localparam int FRAC_SHIFT = 14;
  localparam int Q_W        = SUM_W + 1 - FRAC_SHIFT;

  localparam logic [PEAK_W-1:0] PEAK_MAX   = {PEAK_W{1'b1}};
  localparam logic [SUM_W:0]    ROUND_HALF = (SUM_W + 1)'(1 << (FRAC_SHIFT - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [PEAK_W-1:0]   peak_t;

  // per-stage load strobes of the pipeline
  typedef struct packed {
    logic shift;
    logic ld_prod;
    logic ld_pair;
    logic ld_trip;
    logic ld_sum;
    logic ld_peak;
    logic ld_out;
  } stg_ctl_t;

  // q1.14 polyphase coefficients, one row per phase, tap 0 is the newest sample
  localparam int COEF [PHASES][TAPS] = '{
    '{  28,   180,  -322,   544,  -974,  2250, 15928, -1676,   780,  -436,   244,  -136 },
    '{ -478,  480,  -848,  1460, -2728,  7620, 12776, -3282,  1664,  -954,   542,  -310 },
    '{ -310,  542,  -954,  1664, -3282, 12776,  7620, -2728,  1460,  -848,   480,  -478 },
    '{ -136,  244,  -436,   780, -1676, 15928,  2250,  -974,   544,  -322,   180,    28 }
  };

endpackage

>>> rtl/tpm_if.sv
interface tpm_in_if;
  import tpm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    restart;

  modport source (output valid, output sample_in, output restart, input ready);
  modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;

  logic  valid;
  logic  ready;
  peak_t true_peak;

  modport source (output valid, output true_peak, input ready);
  modport sink   (input valid, input true_peak, output ready);
endinterface

>>> rtl/tpm_tap_cell.sv
module tpm_tap_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpm_pkg::sample_t   tap_in,
  input  logic               restart,
  input  tpm_pkg::stg_ctl_t  ctl,
  output tpm_pkg::sample_t   hist_o,
  output tpm_pkg::prod_t     prod_o [tpm_pkg::PHASES]
);
  import tpm_pkg::*;

  sample_t hist_r;
  sample_t win;
  prod_t   prod_nxt [PHASES];
  prod_t   prod_r   [PHASES];

  // window value for this tap: older taps read zero on a restart request
  assign win = (IDX != 0 && restart) ? '0 : tap_in;

  // history entry, handed to the next cell on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctl.shift) begin
      hist_r <= win;
    end
  end

  // constant products for all phases
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      prod_nxt[p] = win * coef_t'(COEF[p][IDX]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int p = 0; p < PHASES; p++) begin
        prod_r[p] <= prod_nxt[p];
      end
    end
  end

  assign hist_o = hist_r;
  assign prod_o = prod_r;

endmodule

>>> rtl/tpm_sum_tree.sv
module tpm_sum_tree (
  input  logic               clk,
  input  tpm_pkg::stg_ctl_t  ctl,
  input  tpm_pkg::prod_t     prod_i [tpm_pkg::TAPS][tpm_pkg::PHASES],
  output tpm_pkg::sum_t      sum_o  [tpm_pkg::PHASES]
);
  import tpm_pkg::*;

  localparam int PAIRS = TAPS / 2;
  localparam int TRIPS = PAIRS / 2;

  sum_t pair_r [PHASES][PAIRS];
  sum_t trip_r [PHASES][TRIPS];
  sum_t sum_nxt [PHASES];
  sum_t sum_r   [PHASES];

  // first level: neighbouring taps
  always_ff @(posedge clk) begin
    if (ctl.ld_pair) begin
      for (int p = 0; p < PHASES; p++) begin
        for (int j = 0; j < PAIRS; j++) begin
          pair_r[p][j] <= SUM_W'(prod_i[2*j][p]) + SUM_W'(prod_i[2*j+1][p]);
        end
      end
    end
  end

  // second level
  always_ff @(posedge clk) begin
    if (ctl.ld_trip) begin
      for (int p = 0; p < PHASES; p++) begin
        for (int j = 0; j < TRIPS; j++) begin
          trip_r[p][j] <= pair_r[p][2*j] + pair_r[p][2*j+1];
        end
      end
    end
  end

  // final level: three partial sums per phase
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      sum_nxt[p] = '0;
      for (int j = 0; j < TRIPS; j++) begin
        sum_nxt[p] = sum_nxt[p] + trip_r[p][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      for (int p = 0; p < PHASES; p++) begin
        sum_r[p] <= sum_nxt[p];
      end
    end
  end

  assign sum_o = sum_r;

endmodule

>>> rtl/tpm_peak_pick.sv
module tpm_peak_pick (
  input  logic               clk,
  input  tpm_pkg::stg_ctl_t  ctl,
  input  tpm_pkg::sum_t      sum_i [tpm_pkg::PHASES],
  output tpm_pkg::peak_t     peak_o
);
  import tpm_pkg::*;

  logic [SUM_W-1:0] mag   [PHASES];
  logic [SUM_W:0]   rnd   [PHASES];
  logic [Q_W-1:0]   q_raw [PHASES];
  peak_t            q_nxt [PHASES];
  peak_t            q_r   [PHASES];
  peak_t            peak_nxt;
  peak_t            peak_r;

  // magnitude, round half up on the magnitude, clamp to q2.23
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      mag[p]   = sum_i[p][SUM_W-1] ? (~sum_i[p] + 1'b1) : sum_i[p];
      rnd[p]   = {1'b0, mag[p]} + ROUND_HALF;
      q_raw[p] = rnd[p][SUM_W:FRAC_SHIFT];
      q_nxt[p] = (q_raw[p] > Q_W'(PEAK_MAX)) ? PEAK_MAX : q_raw[p][PEAK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_peak) begin
      for (int p = 0; p < PHASES; p++) begin
        q_r[p] <= q_nxt[p];
      end
    end
  end

  // largest phase into the output register
  always_comb begin
    peak_nxt = q_r[0];
    for (int p = 1; p < PHASES; p++) begin
      if (q_r[p] > peak_nxt) begin
        peak_nxt = q_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      peak_r <= peak_nxt;
    end
  end

  assign peak_o = peak_r;

endmodule

>>> rtl/true_peak_meter_4x.sv
// channel  dir  handshake       payload
// in_ch    in   valid / ready   sample_in (s24, q1.23), restart (1)
// out_ch   out  valid / ready   true_peak (u25, q2.23)
//
// one request per clock while out_ch does not stall
// the datapath is a row of 12 tap cells, each with four constant multipliers,
// feeding a registered adder tree, a magnitude stage and an output register
// reset (rst_n low, synchronous) zeroes the delay line and empties the pipeline
// out_ch stalls back-pressure stage by stage; empty stages keep taking requests
module true_peak_meter_4x (
  input logic       clk,
  input logic       rst_n,
  tpm_in_if.sink    in_ch,
  tpm_out_if.source out_ch
);
  import tpm_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;
  stg_ctl_t        ctl;
  sample_t         tap   [TAPS];
  sample_t         hist  [TAPS];
  prod_t           prod  [TAPS][PHASES];
  sum_t            sum   [PHASES];
  peak_t           peak;

  // a stage may load when it is empty or the one after it moves
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    ctl.shift   = in_ch.valid && adv[0];
    ctl.ld_prod = adv[0];
    ctl.ld_pair = adv[1];
    ctl.ld_trip = adv[2];
    ctl.ld_sum  = adv[3];
    ctl.ld_peak = adv[4];
    ctl.ld_out  = adv[5];
  end

  // row of tap cells, newest sample enters cell 0
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tap[i] = in_ch.sample_in;
    end else begin : g_link
      assign tap[i] = hist[i-1];
    end

    tpm_tap_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tap_in  (tap[i]),
      .restart (in_ch.restart),
      .ctl     (ctl),
      .hist_o  (hist[i]),
      .prod_o  (prod[i])
    );
  end

  tpm_sum_tree u_tree (
    .clk    (clk),
    .ctl    (ctl),
    .prod_i (prod),
    .sum_o  (sum)
  );

  tpm_peak_pick u_peak (
    .clk    (clk),
    .ctl    (ctl),
    .sum_i  (sum),
    .peak_o (peak)
  );

  assign in_ch.ready      = adv[0];
  assign out_ch.valid     = vld_r[NSTG-1];
  assign out_ch.true_peak = peak;

endmodule

>>> rtl/tpm_checker.sv
module tpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_true_peak
);

  // full-scale input times the largest phase gain, plus one for rounding
  localparam logic [24:0] GAIN_PEAK = 25'd16968705;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_true_peak))
    else $error("result dropped or changed while stalled");

  // an empty output register never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // results stay within the filter gain
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_true_peak <= GAIN_PEAK)
    else $error("result beyond the filter gain");

  // an accepted request reaches the output while out_ready stays high behind it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind true_peak_meter_4x tpm_checker u_tpm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_true_peak (out_ch.true_peak)
);

>>> verif/tb_true_peak_meter_4x.sv
`timescale 1ns / 1ps

module tb_true_peak_meter_4x;
  import tpm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 12;
  localparam int RANDOM_REQS = 1550;
  localparam int FULL_POS    = 8388607;
  localparam int FULL_NEG    = -8388608;

  // q1.14 interpolation taps per phase, tap 0 holds the newest sample
  localparam int PHASE_TAPS [PHASES][TAPS] = '{
    '{   28,   180,  -322,   544,  -974,  2250, 15928, -1676,   780,  -436,   244,  -136 },
    '{ -478,   480,  -848,  1460, -2728,  7620, 12776, -3282,  1664,  -954,   542,  -310 },
    '{ -310,   542,  -954,  1664, -3282, 12776,  7620, -2728,  1460,  -848,   480,  -478 },
    '{ -136,   244,  -436,   780, -1676, 15928,  2250,  -974,   544,  -322,   180,    28 }
  };

  logic clk;
  logic rst_n;

  tpm_in_if  in_ch ();
  tpm_out_if out_ch ();

  true_peak_meter_4x i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sample_t tap_line [TAPS];
  peak_t   expected_peaks [$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      steady_flow;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // clear the local delay line on a restart, shift one sample in and work out the expected peak
  function automatic peak_t predict_peak(sample_t smp, logic clear);
    longint acc;
    longint mag;
    longint rounded;
    peak_t  peak;
    peak = '0;
    if (clear) begin
      foreach (tap_line[i]) tap_line[i] = '0;
    end
    for (int i = TAPS - 1; i > 0; i--) tap_line[i] = tap_line[i-1];
    tap_line[0] = smp;
    for (int p = 0; p < PHASES; p++) begin
      acc = 0;
      for (int i = 0; i < TAPS; i++) acc += longint'(tap_line[i]) * longint'(PHASE_TAPS[p][i]);
      mag     = (acc < 0) ? -acc : acc;
      rounded = (mag + 8192) >>> 14;
      if (rounded > longint'(PEAK_MAX)) rounded = longint'(PEAK_MAX);
      if (peak_t'(rounded) > peak) peak = peak_t'(rounded);
    end
    return peak;
  endfunction

  // drive one request and hold it until accepted
  task automatic send_sample(int smp, bit clear);
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.sample_in = sample_t'(smp);
    in_ch.restart   = clear;
    do @(posedge clk); while (!in_ch.ready);
    expected_peaks.push_back(predict_peak(sample_t'(smp), clear));
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  // random gap between requests, none once the stream runs steady
  task automatic maybe_gap();
    if (!steady_flow && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
  endtask

  // empty delay line right after reset
  task automatic test_idle_history();
    send_sample(0, 1'b0);
    send_sample(0, 1'b1);
  endtask

  // full scale and near-zero single samples on a cleared line
  task automatic test_full_scale_extremes();
    send_sample(FULL_POS, 1'b1);
    send_sample(FULL_NEG, 1'b1);
    send_sample(-1, 1'b1);
    send_sample(1, 1'b1);
  endtask

  // fill the line with full scale samples matching the signs of phase 1
  task automatic test_worst_case_phase_sum();
    for (int i = TAPS - 1; i >= 0; i--) begin
      send_sample(PHASE_TAPS[1][i] < 0 ? FULL_NEG : FULL_POS, i == TAPS - 1);
    end
  endtask

  // restart on a full line leaves only the new sample
  task automatic test_restart_mid_stream();
    send_sample(FULL_NEG, 1'b1);
    send_sample(12345, 1'b0);
  endtask

  // magnitude exactly half an lsb above a step, both signs
  task automatic test_rounding_half();
    int half_smp;
    half_smp = 1;
    while (((half_smp * 478) % 16384) != 8192) half_smp++;
    send_sample(half_smp, 1'b1);
    send_sample(-half_smp, 1'b1);
  endtask

  // mixed random stream, idling stops for the last fifth
  task automatic test_random_stream();
    int smp;
    int kind;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS * 4 / 5) steady_flow = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 13)
        smp = int'(sample_t'($urandom));
      else if (kind < 16)
        smp = $urandom_range(0, 511) - 256;
      else
        smp = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
      maybe_gap();
      send_sample(smp, $urandom_range(0, 39) == 0);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_peaks.size() == 0) begin
        $error("unexpected result: true_peak actual %0d", out_ch.true_peak);
        mismatch_count++;
      end else begin
        if (out_ch.true_peak !== expected_peaks[0]) begin
          $error("true_peak mismatch: expected %0d actual %0d",
                 expected_peaks[0], out_ch.true_peak);
          mismatch_count++;
        end
        void'(expected_peaks.pop_front());
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (steady_flow) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 11)) begin
          @(negedge clk);
          out_ch.ready = 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 20)) begin
          @(negedge clk);
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    mismatch_count  = 0;
    quiet_cycles    = 0;
    steady_flow     = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.restart   = 1'b0;
    foreach (tap_line[i]) tap_line[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_idle_history();
    test_full_scale_extremes();
    test_worst_case_phase_sum();
    test_restart_mid_stream();
    test_rounding_half();
    test_random_stream();

    wait (expected_peaks.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_peaks.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
